>>> rtl/clbe_pkg.sv
// Shared types and constants for the Chebyshev Lagrange basis evaluator.
package clbe_pkg;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HIGH = 2'd1;

   localparam logic signed [31:0] BOX_LOW_RESET  = 32'sd0;
   localparam logic signed [31:0] BOX_HIGH_RESET = 32'sd16777216;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam int TAYLOR_TERMS = 10;
   localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
      64'd132, 64'd182, 64'd240, 64'd306, 64'd380
   };

   localparam int MAG_W = 35;
   localparam int EXP_W = 12;
   localparam int QUO_W = 33;

   typedef struct packed {
      logic [2:0]         basis_index;
      logic signed [31:0] sample_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] basis_value;
      logic               overflow;
   } rsp_type;

endpackage

>>> rtl/chebyshev_lagrange_basis_eval.sv
// Top level: pipelined Lagrange basis evaluation on Chebyshev nodes.
//
// One transaction enters per cycle whenever start is high; busy is high only during
// reset. Each result appears on rsp_data with rsp_strobe high for one cycle once it
// has passed the pipeline in order: six stages build the nodes and normalized
// factors, one multiply stage per factor runs the numerator and denominator
// products, one stage aligns the quotient and a restoring divider of 33 one-bit
// stages plus an output register finish it. There is no stall path, as the
// receiver always takes results. Write box_low and box_high only with no transaction
// in flight.
module chebyshev_lagrange_basis_eval #(
   parameter int NODE_COUNT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  clbe_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output clbe_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_data
);

   localparam int SLOTS   = NODE_COUNT - 1;
   localparam int NodeDen = 2 * NODE_COUNT;
   localparam int LATENCY = SLOTS + clbe_pkg::QUO_W + 8;
   localparam int MW      = clbe_pkg::MAG_W;
   localparam int EW      = clbe_pkg::EXP_W;
   localparam int QW      = clbe_pkg::QUO_W;

   function automatic logic signed [31:0] cos_ref(input int n_in);
      logic [63:0]        n;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic               neg;
      n   = 64'(n_in);
      neg = 1'b0;
      if (2 * n > 64'(NodeDen)) begin
         n   = 64'(NodeDen) - n;
         neg = 1'b1;
      end
      x    = clbe_pkg::PI_Q30 * n / NodeDen;
      x2   = (x * x) >> 30;
      term = clbe_pkg::ONE_Q30;
      sum  = signed'(clbe_pkg::ONE_Q30);
      for (int k = 1; k <= clbe_pkg::TAYLOR_TERMS; k++) begin
         term = ((term * x2) >> 30) / clbe_pkg::TAYLOR_DIV[k];
         if (k % 2 == 1) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 64'sd0;
      if (sum > signed'(clbe_pkg::ONE_Q30)) sum = signed'(clbe_pkg::ONE_Q30);
      return neg ? 32'(-sum) : 32'(sum);
   endfunction

   function automatic logic [5:0] lead_pos(input logic [MW-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int b = 0; b < MW; b++) begin
         if (v[b]) p = 6'(b);
      end
      return p;
   endfunction

   typedef struct packed {
      logic               bad;
      logic [2:0]         idx;
      logic signed [31:0] t;
   } s0_type;

   typedef struct packed {
      logic                                bad;
      logic [2:0]                          idx;
      logic signed [31:0]                  t;
      logic signed [32:0]                  s;
      logic [NODE_COUNT-1:0][64:0]         prod;
   } s1_type;

   typedef struct packed {
      logic                                bad;
      logic [2:0]                          idx;
      logic signed [31:0]                  t;
      logic [NODE_COUNT-1:0][33:0]         node;
   } s2_type;

   typedef struct packed {
      logic                                bad;
      logic [SLOTS-1:0][34:0]              fn;
      logic [SLOTS-1:0][34:0]              fd;
   } s3_type;

   typedef struct packed {
      logic                                bad;
      logic                                zn;
      logic                                zd;
      logic                                neg;
      logic [SLOTS-1:0][MW-1:0]            magn;
      logic [SLOTS-1:0][MW-1:0]            magd;
   } s4_type;

   typedef struct packed {
      logic                                bad;
      logic                                zn;
      logic                                zd;
      logic                                neg;
      logic [31:0]                         mn;
      logic [31:0]                         md;
      logic [EW-1:0]                       en;
      logic [EW-1:0]                       ed;
      logic [SLOTS-1:0][31:0]              fmn;
      logic [SLOTS-1:0][31:0]              fmd;
      logic [SLOTS-1:0][EW-1:0]            fen;
      logic [SLOTS-1:0][EW-1:0]            fed;
   } chain_type;

   typedef struct packed {
      logic        bad;
      logic        zn;
      logic        zd;
      logic        neg;
      logic        sat;
      logic [31:0] rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic [31:0] md;
   } div_type;

   logic signed [31:0] box_low_ff, box_high_ff;
   logic               accept;

   logic      v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   s0_type    s0_ff;
   s1_type    s1_ff, s1_in;
   s2_type    s2_ff, s2_in;
   s3_type    s3_ff, s3_in;
   s4_type    s4_ff, s4_in;
   logic      cv_ff [SLOTS+1];
   chain_type chain_ff [SLOTS+1];
   chain_type chain0_in;
   logic      dv_ff [QW+1];
   div_type   div_ff [QW+1];
   div_type   div0_in;
   logic      rsp_strobe_ff;
   clbe_pkg::rsp_type rsp_ff, rsp_in;

   assign busy       = reset;
   assign accept     = start && !busy;
   assign csr_ready  = !reset;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_low_ff  <= clbe_pkg::BOX_LOW_RESET;
         box_high_ff <= clbe_pkg::BOX_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            clbe_pkg::CSR_BOX_LOW:  box_low_ff  <= signed'(csr_data);
            clbe_pkg::CSR_BOX_HIGH: box_high_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // node construction
   always_comb begin
      logic signed [32:0] d;
      logic signed [65:0] sum;
      d = 33'(box_high_ff) - 33'(box_low_ff);
      s1_in.bad = s0_ff.bad;
      s1_in.idx = s0_ff.idx;
      s1_in.t   = s0_ff.t;
      s1_in.s   = 33'(box_high_ff) + 33'(box_low_ff);
      for (int j = 0; j < NODE_COUNT; j++) begin
         s1_in.prod[j] = 65'(d) * 65'(cos_ref(2 * (NODE_COUNT - j) - 1));
      end
      s2_in.bad = s1_ff.bad;
      s2_in.idx = s1_ff.idx;
      s2_in.t   = s1_ff.t;
      for (int j = 0; j < NODE_COUNT; j++) begin
         sum = (66'(s1_ff.s) <<< 30) + 66'(signed'(s1_ff.prod[j])) + 66'sd1073741824;
         s2_in.node[j] = sum[64:31];
      end
   end

   // factor differences, skipping the selected node
   always_comb begin
      logic [31:0]        idx_ext;
      logic signed [33:0] node_i;
      logic signed [33:0] node_k;
      idx_ext = {29'd0, s2_ff.idx};
      node_i  = '0;
      for (int j = 0; j < NODE_COUNT; j++) begin
         if (idx_ext == 32'(j)) node_i = signed'(s2_ff.node[j]);
      end
      s3_in.bad = s2_ff.bad;
      for (int k = 0; k < SLOTS; k++) begin
         node_k = (32'(k) < idx_ext) ? signed'(s2_ff.node[k]) : signed'(s2_ff.node[k+1]);
         s3_in.fn[k] = 35'(s2_ff.t) - 35'(node_k);
         s3_in.fd[k] = 35'(node_i) - 35'(node_k);
      end
   end

   // magnitudes, signs and zero detection
   always_comb begin
      s4_in.bad = s3_ff.bad;
      s4_in.zn  = 1'b0;
      s4_in.zd  = 1'b0;
      s4_in.neg = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         s4_in.zn  = s4_in.zn | (s3_ff.fn[k] == '0);
         s4_in.zd  = s4_in.zd | (s3_ff.fd[k] == '0);
         s4_in.neg = s4_in.neg ^ (s3_ff.fn[k][34] ^ s3_ff.fd[k][34]);
         s4_in.magn[k] = s3_ff.fn[k][34] ? (35'd0 - s3_ff.fn[k]) : s3_ff.fn[k];
         s4_in.magd[k] = s3_ff.fd[k][34] ? (35'd0 - s3_ff.fd[k]) : s3_ff.fd[k];
      end
   end

   // factor normalization
   always_comb begin
      logic [5:0] pn, pd;
      chain0_in.bad = s4_ff.bad;
      chain0_in.zn  = s4_ff.zn;
      chain0_in.zd  = s4_ff.zd;
      chain0_in.neg = s4_ff.neg;
      chain0_in.mn  = 32'h8000_0000;
      chain0_in.md  = 32'h8000_0000;
      chain0_in.en  = -EW'(31);
      chain0_in.ed  = -EW'(31);
      for (int k = 0; k < SLOTS; k++) begin
         pn = lead_pos(s4_ff.magn[k]);
         pd = lead_pos(s4_ff.magd[k]);
         chain0_in.fmn[k] = (pn >= 6'd31) ? 32'(s4_ff.magn[k] >> (pn - 6'd31))
                                          : 32'(s4_ff.magn[k] << (6'd31 - pn));
         chain0_in.fmd[k] = (pd >= 6'd31) ? 32'(s4_ff.magd[k] >> (pd - 6'd31))
                                          : 32'(s4_ff.magd[k] << (6'd31 - pd));
         chain0_in.fen[k] = EW'(pn) - EW'(31);
         chain0_in.fed[k] = EW'(pd) - EW'(31);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         cv_ff[0] <= 1'b0;
      end else begin
         v0_ff    <= accept;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         cv_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff.bad   <= {29'd0, req_data.basis_index} >= 32'(NODE_COUNT);
      s0_ff.idx   <= req_data.basis_index;
      s0_ff.t     <= req_data.sample_point;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      chain_ff[0] <= chain0_in;
   end

   // product chain, one factor of each product per stage
   for (genvar c = 1; c <= SLOTS; c++) begin : g_chain
      chain_type chain_in;
      always_comb begin
         logic [63:0] pn, pd;
         chain_in = chain_ff[c-1];
         pn = 64'(chain_ff[c-1].mn) * 64'(chain_ff[c-1].fmn[c-1]);
         pd = 64'(chain_ff[c-1].md) * 64'(chain_ff[c-1].fmd[c-1]);
         if (!chain_ff[c-1].zn) begin
            chain_in.mn = pn[63] ? pn[63:32] : pn[62:31];
            chain_in.en = chain_ff[c-1].en + chain_ff[c-1].fen[c-1]
                        + (pn[63] ? EW'(32) : EW'(31));
         end
         if (!chain_ff[c-1].zd) begin
            chain_in.md = pd[63] ? pd[63:32] : pd[62:31];
            chain_in.ed = chain_ff[c-1].ed + chain_ff[c-1].fed[c-1]
                        + (pd[63] ? EW'(32) : EW'(31));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) cv_ff[c] <= 1'b0;
         else cv_ff[c] <= cv_ff[c-1];
      end
      always_ff @(posedge clock) begin
         chain_ff[c] <= chain_in;
      end
   end

   // quotient alignment
   always_comb begin
      logic signed [EW-1:0] sh;
      logic [EW-1:0]        nsh;
      logic [63:0]          x;
      chain_type            cf;
      cf  = chain_ff[SLOTS];
      sh  = signed'(cf.en) - signed'(cf.ed) + EW'(24);
      nsh = EW'(0) - sh;
      x   = '0;
      if (sh >= 0 && sh <= EW'(32)) x = 64'(cf.mn) << sh[5:0];
      else if (sh < 0 && nsh < EW'(33)) x = 64'(cf.mn) >> nsh[5:0];
      div0_in.bad = cf.bad;
      div0_in.zn  = cf.zn;
      div0_in.zd  = cf.zd;
      div0_in.neg = cf.neg;
      div0_in.sat = sh > EW'(32);
      div0_in.rem = {1'b0, x[63:33]};
      div0_in.low = x[QW-1:0];
      div0_in.quo = '0;
      div0_in.md  = cf.md;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else dv_ff[0] <= cv_ff[SLOTS];
   end
   always_ff @(posedge clock) begin
      div_ff[0] <= div0_in;
   end

   // restoring divider, one quotient bit per stage
   for (genvar s = 1; s <= QW; s++) begin : g_div
      div_type div_in;
      always_comb begin
         logic [32:0] trial;
         div_in = div_ff[s-1];
         trial  = {div_ff[s-1].rem, div_ff[s-1].low[QW-1]};
         div_in.low = {div_ff[s-1].low[QW-2:0], 1'b0};
         if (trial >= {1'b0, div_ff[s-1].md}) begin
            div_in.rem = 32'(trial - {1'b0, div_ff[s-1].md});
            div_in.quo = {div_ff[s-1].quo[QW-2:0], 1'b1};
         end else begin
            div_in.rem = trial[31:0];
            div_in.quo = {div_ff[s-1].quo[QW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[s] <= 1'b0;
         else dv_ff[s] <= dv_ff[s-1];
      end
      always_ff @(posedge clock) begin
         div_ff[s] <= div_in;
      end
   end

   // saturation and special cases
   always_comb begin
      logic [QW-1:0] q, lim;
      div_type       df;
      df  = div_ff[QW];
      lim = df.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      q   = df.quo;
      rsp_in.overflow = 1'b0;
      if (df.sat || q > lim) begin
         q = lim;
         rsp_in.overflow = 1'b1;
      end
      rsp_in.basis_value = df.neg ? signed'(32'(33'd0 - q)) : signed'(q[31:0]);
      if (df.bad || df.zd) begin
         rsp_in.basis_value = '0;
         rsp_in.overflow    = 1'b1;
      end else if (df.zn) begin
         rsp_in.basis_value = '0;
         rsp_in.overflow    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= dv_ff[QW];
   end
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (accept && ({29'd0, req_data.basis_index} >= 32'(NODE_COUNT)))
      |-> ##LATENCY (rsp_strobe && rsp_data.overflow && rsp_data.basis_value == '0))
      else $error("out-of-range basis index not flagged");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[0] && !div_ff[0].zd) |-> div_ff[0].md[31])
      else $error("denominator mantissa not normalized");

endmodule

>>> tb/sv/chebyshev_lagrange_basis_eval_test.sv
// Testbench for the Chebyshev Lagrange basis evaluator: directed and random evaluations.
`timescale 1ns / 1ps

class basis_scoreboard;
   localparam longint ONE_Q30_S = 64'sd1073741824;
   localparam int NODES = 8;

   logic signed [31:0] box_lo;
   logic signed [31:0] box_hi;
   longint cheb_ref [NODES];
   clbe_pkg::rsp_type expected_q [$];
   int errors;

   function new();
      for (int j = 0; j < NODES; j++)
         cheb_ref[j] = cheb_cos(2 * (NODES - j) - 1, 2 * NODES);
      box_lo = clbe_pkg::BOX_LOW_RESET;
      box_hi = clbe_pkg::BOX_HIGH_RESET;
      errors = 0;
   endfunction

   function longint cheb_cos(longint unsigned n, longint unsigned d);
      bit neg;
      longint unsigned x, x2, term;
      longint sum;
      neg = 0;
      if (2 * n > d) begin
         n = d - n;
         neg = 1;
      end
      x = clbe_pkg::PI_Q30 * n / d;
      x2 = (x * x) >> 30;
      term = 64'd1073741824;
      sum = ONE_Q30_S;
      for (int k = 1; k <= 10; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
         if (k & 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30_S) sum = ONE_Q30_S;
      return neg ? -sum : sum;
   endfunction

   function void write_reg(logic [clbe_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == clbe_pkg::CSR_BOX_LOW) box_lo = value;
      else if (idx == clbe_pkg::CSR_BOX_HIGH) box_hi = value;
   endfunction

   function longint node_at(int j);
      longint s2, d2;
      s2 = longint'(box_lo) + longint'(box_hi);
      d2 = longint'(box_hi) - longint'(box_lo);
      return (s2 * ONE_Q30_S + d2 * cheb_ref[j] + ONE_Q30_S) >>> 31;
   endfunction

   function longint unsigned norm(longint unsigned v, inout int e);
      while (v >= 64'h1_0000_0000) begin
         v = v >> 1;
         e++;
      end
      while (v < 64'h8000_0000) begin
         v = v << 1;
         e--;
      end
      return v;
   endfunction

   function longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function clbe_pkg::rsp_type evaluate(clbe_pkg::req_type r);
      clbe_pkg::rsp_type res;
      longint node [NODES];
      longint t, fn, fd;
      longint unsigned mn, md, q, lim, fm;
      int en, ed, fe, sh, idx;
      bit neg, zn, zd;
      idx = r.basis_index;
      t = longint'(r.sample_point);
      mn = 64'h8000_0000;
      md = 64'h8000_0000;
      en = -31;
      ed = -31;
      neg = 0;
      zn = 0;
      zd = 0;
      res = '0;
      if (idx >= NODES) begin
         res.overflow = 1'b1;
         return res;
      end
      for (int j = 0; j < NODES; j++) node[j] = node_at(j);
      for (int j = 0; j < NODES; j++) begin
         if (j == idx) continue;
         fn = t - node[j];
         fd = node[idx] - node[j];
         if (fd == 0) zd = 1;
         if (fn == 0) zn = 1;
         if ((fn < 0) != (fd < 0)) neg = !neg;
         if (!zn) begin
            fe = 0;
            fm = norm(magnitude(fn), fe);
            en += fe;
            mn = norm(mn * fm, en);
         end
         if (!zd) begin
            fe = 0;
            fm = norm(magnitude(fd), fe);
            ed += fe;
            md = norm(md * fm, ed);
         end
      end
      if (zd) begin
         res.overflow = 1'b1;
         return res;
      end
      if (zn) return res;
      sh = en - ed + 24;
      if (sh > 32) q = 64'h1_0000_0000;
      else if (sh >= 0) q = (mn << sh) / md;
      else if (sh >= -32) q = mn / (md << (-sh));
      else q = 0;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (q > lim) begin
         q = lim;
         res.overflow = 1'b1;
      end
      res.basis_value = neg ? 32'(-q) : 32'(q);
      return res;
   endfunction

   function void note_input(clbe_pkg::req_type r);
      expected_q.push_back(evaluate(r));
   endfunction

   function void check_result(clbe_pkg::rsp_type got);
      clbe_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result value %h overflow %b", $time,
                  got.basis_value, got.overflow);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got.basis_value !== want.basis_value) begin
         $display("%0t: basis_value expected %h actual %h", $time,
                  want.basis_value, got.basis_value);
         errors++;
      end
      if (got.overflow !== want.overflow) begin
         $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                  got.overflow);
         errors++;
      end
   endfunction
endclass

module chebyshev_lagrange_basis_eval_test;

   localparam int LATENCY = 48;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   clbe_pkg::req_type req_data;
   logic rsp_strobe;
   clbe_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [clbe_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   basis_scoreboard sb = new();
   bit quiet;

   chebyshev_lagrange_basis_eval dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   initial begin
      #5ms;
      $display("** chebyshev_lagrange_basis_eval: FAILED **");
      $finish;
   end

   task automatic send_eval(logic [2:0] idx, logic [31:0] point);
      clbe_pkg::req_type r;
      r.basis_index = idx;
      r.sample_point = point;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_input(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [clbe_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_box(logic [31:0] lo, logic [31:0] hi);
      drain();
      write_csr(clbe_pkg::CSR_BOX_LOW, lo);
      write_csr(clbe_pkg::CSR_BOX_HIGH, hi);
   endtask

   function automatic logic [31:0] near_point();
      longint lo, hi;
      lo = longint'(sb.box_lo);
      hi = longint'(sb.box_hi);
      return 32'(lo + ((hi - lo) * (longint'($urandom_range(0, 1536)) - 256)) / 1024);
   endfunction

   task automatic random_phase(int count);
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) send_eval(3'($urandom_range(0, 7)), near_point());
         else if (kind < 8)
            send_eval(3'($urandom_range(0, 7)),
                      32'(sb.node_at($urandom_range(0, 7)) + $urandom_range(0, 2) - 1));
         else send_eval(3'($urandom_range(0, 7)), $urandom);
      end
   endtask

   initial begin
      logic [31:0] lo, width;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      quiet = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 8; i++) send_eval(3'(i), 32'(sb.node_at(i)));
      send_eval(3, 32'(sb.node_at(5)));
      send_eval(0, 32'h8000_0000);
      send_eval(7, 32'h7FFF_FFFF);
      send_eval(2, 32'h0);
      send_eval(5, 32'h0080_0000);
      send_eval(6, 32'hFFFF_FFFF);

      set_box(32'h0100_0000, 32'h0100_0000);
      send_eval(1, 32'h0123_4567);
      send_eval(4, 32'h0100_0000);
      set_box(32'h0, 32'h0001_0000);
      send_eval(0, 32'h7FFF_FFFF);
      send_eval(7, 32'h8000_0000);
      set_box(32'h8000_0000, 32'h7FFF_FFFF);
      send_eval(2, 32'h1234_5678);
      send_eval(6, 32'h8000_0000);
      set_box(32'h7FFF_FFFF, 32'h8000_0000);
      send_eval(3, 32'h0);
      send_eval(4, 32'h7FFF_FFFF);
      drain();
      write_csr(2'd2, $urandom);
      write_csr(2'd3, $urandom);

      for (int p = 0; p < 8; p++) begin
         lo = $signed($urandom) >>> $urandom_range(0, 8);
         width = $urandom >> $urandom_range(0, 31);
         if (p == 6) set_box(32'h0, 32'h0100_0000);
         else if ($urandom_range(0, 5) == 0) set_box(lo + width, lo);
         else set_box(lo, lo + width);
         if (p == 7) quiet = 1;
         random_phase(200);
      end

      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (sb.errors == 0) $display("** chebyshev_lagrange_basis_eval: PASSED **");
      else $display("** chebyshev_lagrange_basis_eval: FAILED **");
      $finish;
   end
endmodule

>>> files.f
rtl/clbe_pkg.sv
rtl/chebyshev_lagrange_basis_eval.sv
tb/sv/chebyshev_lagrange_basis_eval_test.sv
